/* src/ppm_frame_sequencer_unit_assert.svh */
// Assertion macros shared by the PPM frame sequencer RTL.
`ifndef PPM_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`define PPM_FRAME_SEQUENCER_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define PPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/ppm_seq_pkg.sv */
// Shared types and constants of the PPM frame sequencer.
`timescale 1ns / 1ps
package ppm_seq_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int TICKS_PER_US_DEF = 2;

    localparam int VALUE_W    = 12;
    localparam int INDEX_W    = 3;
    localparam int TICK_W     = 16;
    localparam int SPENT_W    = 20;
    localparam int CCOUNT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [VALUE_W-1:0]  DEFAULT_US = 12'd1520;
    localparam int                  FRAME_US   = 22500;
    localparam logic [TICK_W-1:0]   DEAD_RESET = 16'd600;
    localparam logic [SPENT_W-1:0]  TICKS_MAX  = 20'hFFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME     = 2'd2;

    // request kinds
    localparam logic MODE_EVENT = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        KIND_GAP       = 2'd0,
        KIND_REMAINDER = 2'd1,
        KIND_SYNC      = 2'd2
    } t_kind;

    typedef struct packed {
        logic               overrun;
        logic               first_channel;
        logic               frame_start;
        t_kind              kind;
        logic [TICK_W-1:0]  interval;
    } t_result;

endpackage

/* src/ppm_seq_store.sv */
// Channel value store: one write port, one read port, reset to the default width.
`timescale 1ns / 1ps
module ppm_seq_store #(
    parameter int MAX_CHANNELS = ppm_seq_pkg::MAX_CHANNELS_DEF,
    parameter int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [IDX_W-1:0]                    i_waddr,
    input  logic [ppm_seq_pkg::VALUE_W-1:0]     i_wdata,
    input  logic [IDX_W-1:0]                    i_raddr,
    output logic [ppm_seq_pkg::VALUE_W-1:0]     o_rdata
);
    logic [ppm_seq_pkg::VALUE_W-1:0] r_mem [MAX_CHANNELS];

    // entries come up at the default pulse width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_mem[i] <= ppm_seq_pkg::DEFAULT_US;
            end
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[i_raddr];

endmodule

/* src/ppm_seq_core.sv */
// Frame state, configuration registers and the per-event interval logic.
`timescale 1ns / 1ps
module ppm_seq_core #(
    parameter int MAX_CHANNELS = ppm_seq_pkg::MAX_CHANNELS_DEF,
    parameter int TICKS_PER_US = ppm_seq_pkg::TICKS_PER_US_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ppm_seq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ppm_seq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                  i_consume,
    input  logic                                  i_mode,
    input  logic [ppm_seq_pkg::INDEX_W-1:0]       i_index,
    input  logic [ppm_seq_pkg::VALUE_W-1:0]       i_value,
    output logic                                  o_res_valid,
    output ppm_seq_pkg::t_result                  o_res
);
    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int FULL_W = ppm_seq_pkg::VALUE_W + $clog2(TICKS_PER_US + 1);
    localparam int FL_RAW = ppm_seq_pkg::FRAME_US * TICKS_PER_US;
    localparam logic [ppm_seq_pkg::TICK_W-1:0] FL_RESET =
        (FL_RAW > 65535) ? 16'hFFFF : ppm_seq_pkg::TICK_W'(FL_RAW);
    localparam int TW = ppm_seq_pkg::TICK_W;
    localparam int SW = ppm_seq_pkg::SPENT_W;
    // wide enough for both the scaled width and the dead time
    localparam int CMP_W = (FULL_W > TW) ? FULL_W : TW;

    logic [ppm_seq_pkg::CCOUNT_W-1:0] r_ch_count;
    logic [TW-1:0]                    r_frame_len;
    logic [TW-1:0]                    r_dead;

    logic             r_in_sync, n_in_sync;
    logic             r_in_gap,  n_in_gap;
    logic [CNT_W-1:0] r_cur_ch,  n_cur_ch;
    logic [SW-1:0]    r_ticks,   n_ticks;

    logic [ppm_seq_pkg::VALUE_W-1:0] store_rdata;
    logic                            store_we;
    logic [CNT_W-1:0]                count;
    logic [FULL_W-1:0]               full;
    logic [TW-1:0]                   add_val;
    logic                            add_en;
    logic [SW:0]                     tick_sum;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_count  <= '0;
            r_frame_len <= FL_RESET;
            r_dead      <= ppm_seq_pkg::DEAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppm_seq_pkg::REG_CHANNEL_COUNT:
                    r_ch_count <= i_cfg_data[ppm_seq_pkg::CCOUNT_W-1:0];
                ppm_seq_pkg::REG_FRAME_LENGTH:  r_frame_len <= i_cfg_data;
                ppm_seq_pkg::REG_DEAD_TIME:     r_dead      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel count clamped to the store depth
    always_comb begin
        if (int'(r_ch_count) > MAX_CHANNELS) count = CNT_W'(MAX_CHANNELS);
        else                                 count = CNT_W'(r_ch_count);
    end

    assign store_we = i_consume && (i_mode == ppm_seq_pkg::MODE_WRITE) &&
                      (int'(i_index) < MAX_CHANNELS);

    ppm_seq_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (store_we),
        .i_waddr (IDX_W'(i_index)),
        .i_wdata (i_value),
        .i_raddr (IDX_W'(r_cur_ch)),
        .o_rdata (store_rdata)
    );

    assign full     = FULL_W'(store_rdata) * FULL_W'(TICKS_PER_US);
    assign tick_sum = (SW+1)'(r_ticks) + (SW+1)'(add_val);

    // next frame state and result for a compare event
    always_comb begin
        n_in_sync   = r_in_sync;
        n_in_gap    = r_in_gap;
        n_cur_ch    = r_cur_ch;
        n_ticks     = r_ticks;
        add_val     = '0;
        add_en      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = ppm_seq_pkg::KIND_GAP;

        if (i_consume && (i_mode == ppm_seq_pkg::MODE_EVENT)) begin
            o_res_valid = 1'b1;
            if (r_in_sync) begin
                // opening gap of a new frame
                o_res.frame_start = 1'b1;
                o_res.interval    = r_dead;
                n_cur_ch          = '0;
                n_in_sync         = 1'b0;
                n_in_gap          = 1'b1;
                n_ticks           = SW'(r_dead);
            end else begin
                o_res.first_channel = (r_cur_ch == '0);
                if ((r_cur_ch < count) && r_in_gap) begin
                    // channel remainder after its separator
                    o_res.kind = ppm_seq_pkg::KIND_REMAINDER;
                    if (CMP_W'(full) < CMP_W'(r_dead)) begin
                        o_res.overrun  = 1'b1;
                        o_res.interval = '0;
                    end else begin
                        o_res.interval = TW'(CMP_W'(full) - CMP_W'(r_dead));
                    end
                    add_val  = o_res.interval;
                    add_en   = 1'b1;
                    n_in_gap = 1'b0;
                    n_cur_ch = r_cur_ch + 1'b1;
                end else if (!r_in_gap) begin
                    o_res.interval = r_dead;
                    add_val        = r_dead;
                    add_en         = 1'b1;
                    n_in_gap       = 1'b1;
                end else begin
                    // sync filler pads out the frame
                    o_res.kind = ppm_seq_pkg::KIND_SYNC;
                    n_in_sync  = 1'b1;
                    if (SW'(r_frame_len) < r_ticks) begin
                        o_res.overrun  = 1'b1;
                        o_res.interval = '0;
                    end else begin
                        o_res.interval = r_frame_len - r_ticks[TW-1:0];
                    end
                end
            end
            if (add_en) begin
                if (tick_sum > (SW+1)'(ppm_seq_pkg::TICKS_MAX)) n_ticks = ppm_seq_pkg::TICKS_MAX;
                else                                           n_ticks = tick_sum[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sync <= 1'b1;
            r_in_gap  <= 1'b0;
            r_cur_ch  <= '0;
            r_ticks   <= '0;
        end else begin
            r_in_sync <= n_in_sync;
            r_in_gap  <= n_in_gap;
            r_cur_ch  <= n_cur_ch;
            r_ticks   <= n_ticks;
        end
    end

endmodule

/* src/ppm_frame_sequencer_unit.sv */
// PPM frame sequencer: one compare event or channel write per request.
// A request is held in the input register, and its result is registered in the result
// register before it appears on the master side; a held result stalls the input register.
// Throughput: one request per cycle while results are taken; the result register advances
// whenever it is empty or being taken, the input register also whenever it is empty.
// Reset (synchronous, active low) empties both registers, restores the channel
// store to its default width and the configuration registers to their defaults.
`timescale 1ns / 1ps
`include "ppm_frame_sequencer_unit_assert.svh"
module ppm_frame_sequencer_unit #(
    parameter int MAX_CHANNELS = ppm_seq_pkg::MAX_CHANNELS_DEF,
    parameter int TICKS_PER_US = ppm_seq_pkg::TICKS_PER_US_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [ppm_seq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppm_seq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [15:0]                         i_s_axis_tdata,  // channel_index[2:0], channel_value[14:3]
    input  logic                                i_s_axis_tuser,  // mode
    // result side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [15:0]                         o_m_axis_tdata,  // interval[15:0]
    output logic [4:0]                          o_m_axis_tuser   // segment_kind[1:0], frame_start[2],
                                                                 // first_channel[3], overrun[4]
);
    logic                                r_in_valid;
    logic                                r_in_mode;
    logic [ppm_seq_pkg::INDEX_W-1:0]     r_in_index;
    logic [ppm_seq_pkg::VALUE_W-1:0]     r_in_value;
    logic                                r_out_valid;
    ppm_seq_pkg::t_result                r_out;

    logic                 out_free;
    logic                 consume;
    logic                 res_valid;
    ppm_seq_pkg::t_result res;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign consume         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_mode  <= i_s_axis_tuser;
            r_in_index <= i_s_axis_tdata[ppm_seq_pkg::INDEX_W-1:0];
            r_in_value <= i_s_axis_tdata[ppm_seq_pkg::INDEX_W +: ppm_seq_pkg::VALUE_W];
        end
    end

    ppm_seq_core #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .TICKS_PER_US (TICKS_PER_US)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_consume   (consume),
        .i_mode      (r_in_mode),
        .i_index     (r_in_index),
        .i_value     (r_in_value),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register; writes produce nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.interval;
    assign o_m_axis_tuser  = {r_out.overrun, r_out.first_channel, r_out.frame_start,
                              r_out.kind};

    // frame opening is always a plain gap
    `PPM_ASSERT(a_start_is_gap, o_m_axis_tvalid && o_m_axis_tuser[2] |-> o_m_axis_tuser[1:0] == ppm_seq_pkg::KIND_GAP, "frame start on a non-gap segment")
    // a gap is never clamped
    `PPM_ASSERT(a_gap_no_overrun, o_m_axis_tvalid && o_m_axis_tuser[4] |-> o_m_axis_tuser[1:0] != ppm_seq_pkg::KIND_GAP, "overrun flagged on a gap")
    // opening event carries neither first-channel nor overrun
    `PPM_ASSERT(a_start_flags, o_m_axis_tvalid && o_m_axis_tuser[2] |-> !o_m_axis_tuser[3] && !o_m_axis_tuser[4], "stray flags on frame start")
    // a result only appears from a consumed compare event
    `PPM_ASSERT(a_out_source, $rose(o_m_axis_tvalid) |-> $past(consume) && $past(r_in_mode) == ppm_seq_pkg::MODE_EVENT, "result without compare event")
    // both registers empty after reset
    `PPM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready, "pipeline not empty after reset")

endmodule
